// ----- hw/rtl/n2w_pkg.sv -----
package n2w_pkg;

  // Field and datapath widths
  localparam int unsigned KEY_W   = 30;  // token_key width
  localparam int unsigned NUM_W   = 32;  // number width
  localparam int unsigned BIN_W   = 31;  // magnitude bits of a non-negative number
  localparam int unsigned DIG_N   = 10;  // decimal digits of a 31-bit value
  localparam int unsigned BCD_W   = 4 * DIG_N;
  localparam int unsigned GRP_W   = 48;  // four 3-digit groups, billions group on top
  localparam int unsigned CNT_W   = 5;   // conversion step counter

  typedef logic [KEY_W-1:0] key_t;
  typedef logic [BCD_W-1:0] bcd_t;

  // Scale words
  localparam key_t KEY_HUNDRED  = 30'd100;
  localparam key_t KEY_THOUSAND = 30'd1000;
  localparam key_t KEY_MILLION  = 30'd1000000;
  localparam key_t KEY_BILLION  = 30'd1000000000;

  // Top-level sequencing
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SPELL
  } top_state_e;

  // Token sequencer phases within one 3-digit group
  typedef enum logic [2:0] {
    SP_IDLE,
    SP_HUND,
    SP_HWORD,
    SP_TENS,
    SP_UNITS,
    SP_SCALE
  } spell_phase_e;

  // Request from the top controller to the token sequencer
  typedef struct packed {
    logic start;
    logic err;
  } spell_req_t;

  // Tens word for a tens digit of 2..9: digit * 10
  function automatic key_t tens_key(logic [3:0] t);
    logic [6:0] v;
    v = {t, 3'b000} + {2'b00, t, 1'b0};
    return {{(KEY_W-7){1'b0}}, v};
  endfunction

  // Single word for 0..19 given tens digit 0 or 1 and units digit
  function automatic key_t teen_key(logic t0, logic [3:0] u);
    logic [4:0] v;
    v = {1'b0, u} + (t0 ? 5'd10 : 5'd0);
    return {{(KEY_W-5){1'b0}}, v};
  endfunction

  // Scale word for group index 3 (billions) .. 1 (thousands)
  function automatic key_t scale_key(logic [1:0] g);
    key_t k;
    case (g)
      2'd3:    k = KEY_BILLION;
      2'd2:    k = KEY_MILLION;
      default: k = KEY_THOUSAND;
    endcase
    return k;
  endfunction

endpackage

// ----- hw/rtl/n2w_bcd.sv -----
module n2w_bcd import n2w_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [BIN_W-1:0] bin_i,
  output logic             done_o,
  output bcd_t             bcd_o
);

  logic [BIN_W-1:0] bin_q, bin_d;
  bcd_t             bcd_q, bcd_d, bcd_adj;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  // Add-3 correction on every digit before the shift
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // One binary bit enters the digit register per cycle
  always_comb begin
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      bin_d  = bin_i;
      bcd_d  = '0;
      cnt_d  = CNT_W'(BIN_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      bcd_d = {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
      bin_d = {bin_q[BIN_W-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// ----- hw/rtl/n2w_spell.sv -----
module n2w_spell import n2w_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  spell_req_t req_i,
  input  bcd_t       bcd_i,
  output logic       done_o,
  output logic       tok_valid_o,
  input  logic       tok_ready_i,
  output key_t       tok_key_o,
  output logic       tok_err_o,
  output logic       tok_last_o
);

  spell_phase_e     phase_q, phase_d;
  logic [GRP_W-1:0] grp_q, grp_d;
  logic [1:0]       gidx_q, gidx_d;
  logic             out_valid_q, out_valid_d;
  key_t             out_key_q, out_key_d;
  logic             out_err_q, out_err_d;
  logic             out_last_q, out_last_d;

  logic [3:0] dig_h, dig_t, dig_u;
  logic       grp_nz, rem_nz, low_z, last_grp, out_free;
  logic       emit, emit_last;
  key_t       emit_key;

  // Current group digits sit in the top 12 bits
  assign dig_h    = grp_q[GRP_W-1 -: 4];
  assign dig_t    = grp_q[GRP_W-5 -: 4];
  assign dig_u    = grp_q[GRP_W-9 -: 4];
  assign grp_nz   = (grp_q[GRP_W-1 -: 12] != '0);
  assign rem_nz   = (dig_t != '0) || (dig_u != '0);
  assign low_z    = (grp_q[GRP_W-13:0] == '0);
  assign last_grp = (gidx_q == 2'd0);
  assign out_free = !out_valid_q || tok_ready_i;

  // Phase sequencer: one word or one skip per cycle; a word holds while the output is stalled
  always_comb begin
    phase_d   = phase_q;
    grp_d     = grp_q;
    gidx_d    = gidx_q;
    emit      = 1'b0;
    emit_key  = '0;
    emit_last = 1'b0;
    case (phase_q)
      SP_IDLE: begin
        if (req_i.start && !req_i.err && (bcd_i != '0)) begin
          grp_d   = {{(GRP_W-BCD_W){1'b0}}, bcd_i};
          gidx_d  = 2'd3;
          phase_d = SP_HUND;
        end
      end
      SP_HUND: begin
        if (!grp_nz) begin
          grp_d  = {grp_q[GRP_W-13:0], 12'h000};
          gidx_d = gidx_q - 1'b1;
        end else if (dig_h != '0) begin
          emit     = 1'b1;
          emit_key = {{(KEY_W-4){1'b0}}, dig_h};
          if (out_free) phase_d = SP_HWORD;
        end else begin
          phase_d = SP_TENS;
        end
      end
      SP_HWORD: begin
        emit      = 1'b1;
        emit_key  = KEY_HUNDRED;
        emit_last = !rem_nz && last_grp;
        if (out_free) begin
          if (rem_nz)        phase_d = SP_TENS;
          else if (last_grp) phase_d = SP_IDLE;
          else               phase_d = SP_SCALE;
        end
      end
      SP_TENS: begin
        emit = 1'b1;
        if (dig_t >= 4'd2) begin
          emit_key  = tens_key(dig_t);
          emit_last = (dig_u == '0) && last_grp;
          if (out_free) begin
            if (dig_u != '0)   phase_d = SP_UNITS;
            else if (last_grp) phase_d = SP_IDLE;
            else               phase_d = SP_SCALE;
          end
        end else begin
          emit_key  = teen_key(dig_t[0], dig_u);
          emit_last = last_grp;
          if (out_free) phase_d = last_grp ? SP_IDLE : SP_SCALE;
        end
      end
      SP_UNITS: begin
        emit      = 1'b1;
        emit_key  = {{(KEY_W-4){1'b0}}, dig_u};
        emit_last = last_grp;
        if (out_free) phase_d = last_grp ? SP_IDLE : SP_SCALE;
      end
      SP_SCALE: begin
        emit      = 1'b1;
        emit_key  = scale_key(gidx_q);
        emit_last = low_z;
        if (out_free) begin
          if (low_z) begin
            phase_d = SP_IDLE;
          end else begin
            grp_d   = {grp_q[GRP_W-13:0], 12'h000};
            gidx_d  = gidx_q - 1'b1;
            phase_d = SP_HUND;
          end
        end
      end
      default: phase_d = SP_IDLE;
    endcase
  end

  // Output register; error and zero give one token right at start
  always_comb begin
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    out_err_d   = out_err_q;
    out_last_d  = out_last_q;
    if (req_i.start && (req_i.err || (bcd_i == '0))) begin
      out_valid_d = 1'b1;
      out_key_d   = '0;
      out_err_d   = req_i.err;
      out_last_d  = 1'b1;
    end else if (emit && out_free) begin
      out_valid_d = 1'b1;
      out_key_d   = emit_key;
      out_err_d   = 1'b0;
      out_last_d  = emit_last;
    end else if (tok_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= SP_IDLE;
      gidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      gidx_q      <= gidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q      <= grp_d;
    out_key_q  <= out_key_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  assign tok_valid_o = out_valid_q;
  assign tok_key_o   = out_key_q;
  assign tok_err_o   = out_err_q;
  assign tok_last_o  = out_last_q;
  assign done_o      = out_valid_q && tok_ready_i && out_last_q;

endmodule

// ----- hw/rtl/number_to_word_tokens_unit.sv -----
// Channel | Direction | tdata                        | tuser    | tlast
// s_axis  | in        | [31:0] number (signed)       | -        | -
// m_axis  | out       | [29:0] token_key, [31:30] 0  | is_error | last token of a run
//
// A non-negative number takes its transfer, bit-serial binary to BCD conversion, a
// hand-over of the digits to the sequencer, then one sequencer step per word plus skips
// of zero groups and of zero hundreds digits (at most 17 steps), and the transfer of
// the last token. A negative number gives its error token in the cycle after the
// transfer. Reset clears all control state; the next number is taken after the last
// token of a run has been transferred.
// A stall on m_axis holds the sequencer at its current word.
module number_to_word_tokens_unit import n2w_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [NUM_W-1:0]  s_axis_tdata,   // [31:0] number
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [31:0]       m_axis_tdata,   // [29:0] token_key, [31:30] zero
  output logic              m_axis_tuser,   // [0] is_error
  output logic              m_axis_tlast
);

  top_state_e state_q, state_d;
  spell_req_t spell_req;
  logic       in_xfer, bcd_start, bcd_done, spell_done;
  bcd_t       bcd;
  key_t       tok_key;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Sequencing between conversion and spelling
  always_comb begin
    state_d         = state_q;
    bcd_start       = 1'b0;
    spell_req.start = 1'b0;
    spell_req.err   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tdata[NUM_W-1]) begin
            spell_req.start = 1'b1;
            spell_req.err   = 1'b1;
            state_d         = ST_SPELL;
          end else begin
            bcd_start = 1'b1;
            state_d   = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        if (bcd_done) begin
          spell_req.start = 1'b1;
          state_d         = ST_SPELL;
        end
      end
      ST_SPELL: begin
        if (spell_done) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  n2w_bcd u_bcd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (bcd_start),
    .bin_i   (s_axis_tdata[BIN_W-1:0]),
    .done_o  (bcd_done),
    .bcd_o   (bcd)
  );

  n2w_spell u_spell (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (spell_req),
    .bcd_i       (bcd),
    .done_o      (spell_done),
    .tok_valid_o (m_axis_tvalid),
    .tok_ready_i (m_axis_tready),
    .tok_key_o   (tok_key),
    .tok_err_o   (m_axis_tuser),
    .tok_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, tok_key};

endmodule
